// ===== design/assert_macros.svh =====
// Assertion macros shared by the cache tag check RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/dmc_pkg.sv =====
// Package for the direct-mapped cache tag check: configuration types,
// register map and reset values. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dmc_pkg;

  // Live configuration seen by the front end.
  typedef struct packed {
    logic [2:0] offset_bits;
    logic [3:0] index_bits;
  } cfg_t;

  // Register map, indexed by word.
  typedef enum logic {
    REG_OFFSET_BITS = 1'b0,
    REG_INDEX_BITS  = 1'b1
  } reg_idx_t;

  localparam logic [2:0] OFFSET_BITS_RESET = 3'd4;
  localparam logic [3:0] INDEX_BITS_RESET  = 4'd8;

  // Decoupling queue between classification and tag lookup.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

`default_nettype wire

// ===== design/dmc_front.sv =====
// Front end of the cache tag check: takes address beats and splits them
// into line index and tag. Depends on dmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dmc_front #(
  parameter int LINE_W = 8,
  parameter int TAG_W  = 32,
  parameter int MAX_IB = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire dmc_pkg::cfg_t      cfg,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [31:0]        in_address,
  output logic                    fe_valid,
  input  wire logic               fe_ready,
  output logic [LINE_W-1:0]       fe_idx,
  output logic [TAG_W-1:0]        fe_tag
);

  localparam logic [4:0] MAX_IB_C = 5'(MAX_IB);

  logic              fe_valid_r;
  logic              fe_valid_nxt;
  logic [LINE_W-1:0] fe_idx_r;
  logic [TAG_W-1:0]  fe_tag_r;
  logic [4:0]        ib_c;
  logic [31:0]       addr_c;
  logic [31:0]       line_c;
  logic [31:0]       tag_c;
  logic              accept_c;

  // Clamp the index width to what the line store can hold.
  always_comb begin
    if ({1'b0, cfg.index_bits} > MAX_IB_C) begin
      ib_c = MAX_IB_C;
    end else begin
      ib_c = {1'b0, cfg.index_bits};
    end
  end

  // Split the masked address into line index and tag.
  assign addr_c = 32'(in_address[TAG_W-1:0]);
  assign line_c = (addr_c >> cfg.offset_bits) & ~(32'hFFFF_FFFF << ib_c);
  assign tag_c  = addr_c >> ({2'b00, cfg.offset_bits} + ib_c);

  // One holding stage; it frees up whenever the queue takes its beat.
  assign in_ready = !fe_valid_r || fe_ready;
  assign accept_c = in_valid && in_ready;

  always_comb begin
    fe_valid_nxt = fe_valid_r;
    if (accept_c) begin
      fe_valid_nxt = 1'b1;
    end else if (fe_ready) begin
      fe_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fe_valid_r <= 1'b0;
    end else begin
      fe_valid_r <= fe_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_c) begin
      fe_idx_r <= line_c[LINE_W-1:0];
      fe_tag_r <= tag_c[TAG_W-1:0];
    end
  end

  assign fe_valid = fe_valid_r;
  assign fe_idx   = fe_idx_r;
  assign fe_tag   = fe_tag_r;

endmodule

`default_nettype wire

// ===== design/dmc_queue.sv =====
// Short FIFO that decouples the front end from the tag lookup.
// Depends on dmc_pkg for its depth.
`timescale 1ns / 1ps
`default_nettype none

module dmc_queue #(
  parameter int WIDTH = 40
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);

  logic [WIDTH-1:0]           slot_r [dmc_pkg::QUEUE_DEPTH];
  logic [dmc_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [dmc_pkg::QPTR_W-1:0] wr_ptr_nxt;
  logic [dmc_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [dmc_pkg::QPTR_W-1:0] rd_ptr_nxt;
  logic [dmc_pkg::QCNT_W-1:0] count_r;
  logic [dmc_pkg::QCNT_W-1:0] count_nxt;
  logic                       push_c;
  logic                       pop_c;

  assign push_ready = (count_r != dmc_pkg::QCNT_W'(dmc_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign push_c     = push_valid && push_ready;
  assign pop_c      = pop_valid && pop_ready;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_c) begin
      wr_ptr_nxt = (wr_ptr_r == dmc_pkg::QPTR_W'(dmc_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop_c) begin
      rd_ptr_nxt = (rd_ptr_r == dmc_pkg::QPTR_W'(dmc_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push_c && !pop_c) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_c && !push_c) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_c) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== design/dmc_back.sv =====
// Back end of the cache tag check: tag memory, valid bits, read-compare-
// write and the saturating counters with the result register. Depends on dmc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dmc_back #(
  parameter int LINES  = 256,
  parameter int LINE_W = 8,
  parameter int TAG_W  = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              clear,
  input  wire logic              q_valid,
  output logic                   q_pop,
  input  wire logic [LINE_W-1:0] q_idx,
  input  wire logic [TAG_W-1:0]  q_tag,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_hit,
  output logic [31:0]            out_lookup_count,
  output logic [31:0]            out_miss_count
);

  logic [TAG_W-1:0]  tag_mem [LINES];
  logic [LINES-1:0]  line_valid_r;
  logic [LINES-1:0]  line_valid_nxt;

  logic              b_valid_r;
  logic              b_valid_nxt;
  logic [LINE_W-1:0] b_idx_r;
  logic [TAG_W-1:0]  b_tag_r;
  logic [TAG_W-1:0]  rd_tag_r;
  logic              collide_r;
  logic [TAG_W-1:0]  fwd_tag_r;

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              out_hit_r;
  logic [31:0]       lookups_r;
  logic [31:0]       lookups_nxt;
  logic [31:0]       misses_r;
  logic [31:0]       misses_nxt;

  logic              retire_c;
  logic              take_c;
  logic              hit_c;
  logic              miss_we_c;
  logic [TAG_W-1:0]  line_tag_c;

  // The lookup stage moves on when the result register is free or drained.
  assign retire_c = b_valid_r && (!out_valid_r || out_ready);
  assign take_c   = q_valid && (!b_valid_r || retire_c);
  assign q_pop    = take_c;

  // A miss to the same line retiring in the same cycle as the read is forwarded to the next lookup.
  assign line_tag_c = collide_r ? fwd_tag_r : rd_tag_r;
  assign hit_c      = line_valid_r[b_idx_r] && (line_tag_c == b_tag_r);
  assign miss_we_c  = retire_c && !hit_c;

  // Tag memory: write on miss, registered read for the next lookup.
  always_ff @(posedge clk) begin
    if (miss_we_c) begin
      tag_mem[b_idx_r] <= b_tag_r;
    end
    if (take_c) begin
      rd_tag_r <= tag_mem[q_idx];
    end
  end

  // Valid bits: set on miss, cleared at once by a configuration write.
  always_comb begin
    line_valid_nxt = line_valid_r;
    if (clear) begin
      line_valid_nxt = '0;
    end else if (miss_we_c) begin
      line_valid_nxt[b_idx_r] = 1'b1;
    end
  end

  // Saturating counters, which also serve as the result counts.
  always_comb begin
    lookups_nxt = lookups_r;
    misses_nxt  = misses_r;
    if (retire_c) begin
      if (lookups_r != 32'hFFFF_FFFF) begin
        lookups_nxt = lookups_r + 32'd1;
      end
      if (!hit_c && misses_r != 32'hFFFF_FFFF) begin
        misses_nxt = misses_r + 32'd1;
      end
    end
  end

  // Occupancy of the lookup stage and the result register.
  always_comb begin
    b_valid_nxt = b_valid_r;
    if (take_c) begin
      b_valid_nxt = 1'b1;
    end else if (retire_c) begin
      b_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (retire_c) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_valid_r <= '0;
      b_valid_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      lookups_r    <= '0;
      misses_r     <= '0;
    end else begin
      line_valid_r <= line_valid_nxt;
      b_valid_r    <= b_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      lookups_r    <= lookups_nxt;
      misses_r     <= misses_nxt;
    end
  end

  // Lookup stage payload and the forwarding record.
  always_ff @(posedge clk) begin
    if (take_c) begin
      b_idx_r   <= q_idx;
      b_tag_r   <= q_tag;
      collide_r <= miss_we_c && (b_idx_r == q_idx);
      fwd_tag_r <= b_tag_r;
    end
    if (retire_c) begin
      out_hit_r <= hit_c;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_lookup_count = lookups_r;
  assign out_miss_count   = misses_r;

endmodule

`default_nettype wire

// ===== design/direct_mapped_cache_tag_check.sv =====
// Direct-mapped cache tag check. Each address beat is split into line index
// and tag, looked up in a LINES-entry tag store and answered with hit or miss
// plus saturating lookup and miss counts. The block sustains one address per
// clock while the receiver keeps out_ready high. A result passes through the
// front register, a queue slot, the tag memory read and the result register in
// that order; the one-per-clock figure is set by the single tag read and write
// per cycle of the tag memory.
// Writing either configuration register clears all valid bits at once;
// write registers only while no lookup is in flight. Depends on dmc_pkg,
// dmc_front, dmc_queue, dmc_back and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module direct_mapped_cache_tag_check #(
  parameter int LINES         = 256,
  parameter int ADDRESS_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_address,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_hit,
  output logic [31:0]      out_lookup_count,
  output logic [31:0]      out_miss_count
);

  localparam int LINE_W = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int MAX_IB = $clog2(LINES + 1) - 1;
  localparam int TAG_W  = (ADDRESS_WIDTH < 32) ? ADDRESS_WIDTH : 32;
  localparam int QW     = LINE_W + TAG_W;

  dmc_pkg::cfg_t     cfg_r;
  dmc_pkg::cfg_t     cfg_nxt;
  logic              wr_c;
  logic              clear_c;
  logic              fe_valid;
  logic              fe_ready;
  logic [LINE_W-1:0] fe_idx;
  logic [TAG_W-1:0]  fe_tag;
  logic              q_valid;
  logic              q_pop;
  logic [QW-1:0]     q_data;

  // Register port: writes land on the access beat, reads are immediate.
  assign pready = 1'b1;
  assign wr_c   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    clear_c = 1'b0;
    if (wr_c) begin
      unique case (dmc_pkg::reg_idx_t'(paddr[2]))
        dmc_pkg::REG_OFFSET_BITS: begin
          cfg_nxt.offset_bits = pwdata[2:0];
          clear_c = 1'b1;
        end
        dmc_pkg::REG_INDEX_BITS: begin
          cfg_nxt.index_bits = pwdata[3:0];
          clear_c = 1'b1;
        end
        default: begin
          clear_c = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    unique case (dmc_pkg::reg_idx_t'(paddr[2]))
      dmc_pkg::REG_OFFSET_BITS: prdata = 32'(cfg_r.offset_bits);
      dmc_pkg::REG_INDEX_BITS:  prdata = 32'(cfg_r.index_bits);
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.offset_bits <= dmc_pkg::OFFSET_BITS_RESET;
      cfg_r.index_bits  <= dmc_pkg::INDEX_BITS_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Address classification.
  dmc_front #(
    .LINE_W (LINE_W),
    .TAG_W  (TAG_W),
    .MAX_IB (MAX_IB)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_address (in_address),
    .fe_valid   (fe_valid),
    .fe_ready   (fe_ready),
    .fe_idx     (fe_idx),
    .fe_tag     (fe_tag)
  );

  // Decoupling queue.
  dmc_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fe_valid),
    .push_ready (fe_ready),
    .push_data  ({fe_idx, fe_tag}),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop),
    .pop_data   (q_data)
  );

  // Tag lookup and counters.
  dmc_back #(
    .LINES  (LINES),
    .LINE_W (LINE_W),
    .TAG_W  (TAG_W)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .clear            (clear_c),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .q_idx            (q_data[QW-1:TAG_W]),
    .q_tag            (q_data[TAG_W-1:0]),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hit          (out_hit),
    .out_lookup_count (out_lookup_count),
    .out_miss_count   (out_miss_count)
  );

  // Misses can never outnumber lookups.
  `ASSERT_IMPL(a_miss_le_lookup, clk, rst_n, out_valid, out_miss_count <= out_lookup_count)
  // A miss result always carries a nonzero miss count.
  `ASSERT_IMPL(a_miss_counted, clk, rst_n, out_valid && !out_hit, out_miss_count != '0)
  // A delivered result is never shown again with the same lookup count, unless that count has saturated.
  `ASSERT_NEXT(a_no_repeat, clk, rst_n, out_valid && out_ready && out_lookup_count != '1, !out_valid || out_lookup_count != $past(out_lookup_count))

endmodule

`default_nettype wire

// ===== sim/tb_direct_mapped_cache_tag_check.sv =====
// Testbench for direct_mapped_cache_tag_check: directed and random address beats
// are checked against an in-bench tag store model, under random idling and stalls.
// Depends on dmc_pkg and the direct_mapped_cache_tag_check RTL.
`timescale 1ns / 1ps

module tb_direct_mapped_cache_tag_check;

  localparam int unsigned LINES            = 256;
  localparam int unsigned MAX_INDEX_BITS   = $clog2(LINES + 1) - 1;
  localparam int unsigned PIPE_LATENCY     = 4;
  localparam int unsigned LONG_HOLD_CYCLES = 120;
  localparam int unsigned CYCLE_LIMIT      = 500000;
  localparam int unsigned HOT_SET_SIZE     = 8;

  typedef struct packed {
    logic        hit;
    logic [31:0] lookup_count;
    logic [31:0] miss_count;
  } lookup_result_t;

  // Clock, reset and block ports.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_hit;
  logic [31:0] out_lookup_count;
  logic [31:0] out_miss_count;

  // Model of the tag store and its configuration.
  dmc_pkg::cfg_t model_cfg;
  bit            model_line_valid [0:LINES-1];
  logic [31:0]   model_line_tag [0:LINES-1];
  logic [31:0]   model_lookups;
  logic [31:0]   model_misses;

  lookup_result_t pending_results[$];
  int unsigned    result_errors = 0;
  int unsigned    results_seen = 0;
  int unsigned    cycle_count = 0;

  // Receiver and sender idling controls.
  bit          no_idle = 1'b0;
  bit          long_hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned burst_left = 0;

  logic [31:0] hot_addr [0:HOT_SET_SIZE-1];

  direct_mapped_cache_tag_check u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_address       (in_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_hit          (out_hit),
    .out_lookup_count (out_lookup_count),
    .out_miss_count   (out_miss_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Looks up one address in the model and queues the result it must produce.
  function automatic void predict_lookup(input logic [31:0] addr);
    int unsigned    used_index_bits;
    logic [31:0]    line_sel;
    logic [31:0]    addr_tag;
    lookup_result_t res;
    used_index_bits = (model_cfg.index_bits > MAX_INDEX_BITS) ? MAX_INDEX_BITS
                                                              : model_cfg.index_bits;
    line_sel = (addr >> model_cfg.offset_bits) & ((32'd1 << used_index_bits) - 32'd1);
    addr_tag = addr >> (model_cfg.offset_bits + used_index_bits);
    res.hit = model_line_valid[line_sel] && (model_line_tag[line_sel] == addr_tag);
    if (!res.hit) begin
      model_line_valid[line_sel] = 1'b1;
      model_line_tag[line_sel] = addr_tag;
      if (model_misses != '1) model_misses++;
    end
    if (model_lookups != '1) model_lookups++;
    res.lookup_count = model_lookups;
    res.miss_count = model_misses;
    pending_results.push_back(res);
  endfunction

  // Result checker: every accepted beat is compared with the oldest prediction.
  always @(posedge clk) begin : result_checker
    lookup_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        result_errors++;
        if (result_errors <= 10)
          $display("result %0d: no lookup pending, got hit=%0b lookups=%0d misses=%0d",
                   results_seen, out_hit, out_lookup_count, out_miss_count);
      end else begin
        want = pending_results.pop_front();
        if (out_hit !== want.hit || out_lookup_count !== want.lookup_count ||
            out_miss_count !== want.miss_count) begin
          result_errors++;
          if (result_errors <= 10)
            $display("result %0d: expected hit=%0b lookups=%0d misses=%0d, got hit=%0b lookups=%0d misses=%0d",
                     results_seen, want.hit, want.lookup_count, want.miss_count,
                     out_hit, out_lookup_count, out_miss_count);
        end
      end
    end
  end

  // Receiver: random ready bursts, an optional long hold, and none at all near the end.
  always @(posedge clk) begin : result_ready_driver
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      burst_left = $urandom_range(0, 14);
    end else begin
      out_ready <= 1'b1;
      burst_left = $urandom_range(0, 40);
    end
  end

  // Sends one address beat, optionally after a random gap, and predicts it once taken.
  task automatic send_address(input logic [31:0] addr, input bit allow_gap);
    int unsigned gap;
    if (allow_gap && !no_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_address <= addr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_lookup(addr);
  endtask

  // Stops sending and waits until every predicted result has been received.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Brings the block to rest so that a register may be written.
  task automatic wait_idle();
    wait_drained();
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // Register write with a setup beat and an access beat, then an idle port;
  // unused upper data bits carry whatever the caller passes in.
  task automatic write_register(input dmc_pkg::reg_idx_t idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == dmc_pkg::REG_OFFSET_BITS) model_cfg.offset_bits = value[2:0];
    else model_cfg.index_bits = value[3:0];
    foreach (model_line_valid[i]) model_line_valid[i] = 1'b0;
    @(posedge clk);
  endtask

  task automatic set_geometry(input logic [2:0] offset_bits, input logic [3:0] index_bits);
    wait_idle();
    write_register(dmc_pkg::REG_OFFSET_BITS, ($urandom & ~32'h7) | offset_bits);
    write_register(dmc_pkg::REG_INDEX_BITS, ($urandom & ~32'hF) | index_bits);
  endtask

  // Fills the working set, sometimes packed into a small region.
  task automatic refresh_hot_set();
    logic [31:0] region;
    region = ($urandom_range(0, 1) == 0) ? 32'h0000_3FFF : 32'hFFFF_FFFF;
    foreach (hot_addr[i]) hot_addr[i] = $urandom & region;
  endtask

  // Mostly accesses near the working set so that hits and conflicts are common.
  function automatic logic [31:0] pick_address();
    int unsigned split;
    int unsigned pick;
    logic [31:0] block_mask;
    split = model_cfg.offset_bits +
            ((model_cfg.index_bits > MAX_INDEX_BITS) ? MAX_INDEX_BITS : model_cfg.index_bits);
    block_mask = (32'd1 << model_cfg.offset_bits) - 32'd1;
    pick = $urandom_range(0, 99);
    if (pick < 55)
      return hot_addr[$urandom_range(0, HOT_SET_SIZE - 1)] ^ ($urandom & block_mask);
    else if (pick < 75)
      return hot_addr[$urandom_range(0, HOT_SET_SIZE - 1)] ^ (32'd1 << $urandom_range(split, 31));
    else
      return $urandom;
  endfunction

  task automatic send_random_stream(input int unsigned count, input bit allow_gap);
    repeat (count) send_address(pick_address(), allow_gap);
  endtask

  // Default geometry: same block, same line with a new tag, all-ones address,
  // and a rewrite of a register with its current value clearing the valid bits.
  task automatic test_default_geometry();
    send_address(32'h0000_0000, 1'b1);
    send_address(32'h0000_000F, 1'b1);
    send_address(32'h0000_0010, 1'b1);
    send_address(32'h0000_1000, 1'b1);
    send_address(32'h0000_0000, 1'b1);
    send_address(32'hFFFF_FFFF, 1'b1);
    send_address(32'hFFFF_FFF0, 1'b1);
    send_address(32'hFFFF_FFFF, 1'b1);
    send_address(32'h8000_0000, 1'b1);
    send_address(32'h7FFF_FFFF, 1'b1);
    wait_idle();
    write_register(dmc_pkg::REG_INDEX_BITS, {28'h0, dmc_pkg::INDEX_BITS_RESET});
    send_address(32'hFFFF_FFFF, 1'b1);
    send_address(32'hFFFF_FFFF, 1'b1);
  endtask

  // Geometry extremes: one line holding the whole address as tag, the largest
  // offset, and an index width that must be clamped.
  task automatic test_geometry_extremes();
    set_geometry(3'd0, 4'd0);
    send_address(32'h1234_5678, 1'b1);
    send_address(32'h1234_5678, 1'b1);
    send_address(32'h1234_5679, 1'b1);
    set_geometry(3'd7, 4'd15);
    send_address(32'hFFFF_FF80, 1'b1);
    send_address(32'hFFFF_FFFF, 1'b1);
    send_address(32'h0000_7F80, 1'b1);
    send_address(32'hFFFF_7F80, 1'b1);
    send_address(32'hFFFF_FFFF, 1'b1);
    set_geometry(3'd6, 4'd8);
    send_address(32'h0000_0040, 1'b1);
    send_address(32'h0000_007F, 1'b1);
    send_address(32'h0000_4040, 1'b1);
  endtask

  // Random streams, each phase with its own geometry and working set.
  task automatic test_random_phases(input int unsigned phases, input int unsigned per_phase);
    for (int unsigned p = 0; p < phases; p++) begin
      case (p)
        0: set_geometry(3'd4, 4'd8);
        1: set_geometry(3'd0, 4'd0);
        2: set_geometry(3'd7, 4'd15);
        3: set_geometry(3'd2, 4'd3);
        default: set_geometry(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)));
      endcase
      refresh_hot_set();
      send_random_stream(per_phase, 1'b1);
    end
  endtask

  // The receiver holds off while the sender keeps offering beats back to back.
  task automatic test_output_backpressure();
    set_geometry(3'd3, 4'd5);
    refresh_hot_set();
    long_hold_req = 1'b1;
    send_random_stream(40, 1'b0);
  endtask

  // The sender pauses until every result is back, then resumes on warm lines.
  task automatic test_drain_pause();
    refresh_hot_set();
    send_random_stream(40, 1'b1);
    wait_drained();
    send_random_stream(40, 1'b1);
  endtask

  // Closing stretch with neither side idling.
  task automatic test_full_rate();
    wait_idle();
    no_idle = 1'b1;
    set_geometry(3'($urandom_range(0, 6)), 4'($urandom_range(0, 8)));
    refresh_hot_set();
    send_random_stream(200, 1'b1);
  endtask

  initial begin
    model_cfg.offset_bits = dmc_pkg::OFFSET_BITS_RESET;
    model_cfg.index_bits = dmc_pkg::INDEX_BITS_RESET;
    foreach (model_line_valid[i]) begin
      model_line_valid[i] = 1'b0;
      model_line_tag[i] = '0;
    end
    model_lookups = '0;
    model_misses = '0;
    foreach (hot_addr[i]) hot_addr[i] = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_geometry();
    test_geometry_extremes();
    test_random_phases(8, 135);
    test_output_backpressure();
    test_drain_pause();
    test_full_rate();
    wait_idle();

    if (result_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
